[rtl/dq_pkg.sv]
package dq_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 11;

  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WAIT = 1'b1
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

[rtl/dq_req_if.sv]
interface dq_req_if;
  import dq_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [DATA_W-1:0] data_in;
  logic [SIZE_W-1:0] item_size;

  modport source (output valid, output req_type, output data_in, output item_size,
                  input ready);
  modport sink   (input valid, input req_type, input data_in, input item_size,
                  output ready);
endinterface

[rtl/dq_rsp_if.sv]
interface dq_rsp_if;
  import dq_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   out_value;
  logic [SIZE_W-1:0]   out_size;
  logic [FILL_W-1:0]   fill_count;

  modport source (output valid, output status, output out_value, output out_size,
                  output fill_count, input ready);
  modport sink   (input valid, input status, input out_value, input out_size,
                  input fill_count, output ready);
endinterface

[rtl/dq_mem.sv]
module dq_mem #(
  parameter int unsigned DEPTH = dq_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = dq_pkg::DATA_WIDTH_DEF + dq_pkg::SIZE_W
) (
  input  logic                     clk_i,
  input  dq_pkg::mem_ctl_t         ctl_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);
  import dq_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/dq_ctrl.sv]
module dq_ctrl #(
  parameter int unsigned CAPACITY   = dq_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  dq_req_if.sink                                req_i,
  dq_rsp_if.source                              rsp_o,
  output dq_pkg::mem_ctl_t                      mem_ctl_o,
  output logic [$clog2(CAPACITY)-1:0]           mem_wr_addr_o,
  output logic [DATA_WIDTH+dq_pkg::SIZE_W-1:0]  mem_wr_data_o,
  output logic [$clog2(CAPACITY)-1:0]           mem_rd_addr_o,
  input  logic [DATA_WIDTH+dq_pkg::SIZE_W-1:0]  mem_rd_data_i
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned MW = DATA_WIDTH + SIZE_W;

  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]    count_q, count_d;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic [SIZE_W-1:0] out_size_q, out_size_d;
  logic [FILL_W-1:0] out_fill_q, out_fill_d;

  status_e          pend_status_q;
  logic [FILL_W-1:0] pend_fill_q;
  logic             pend_read_q;

  logic             accept, out_free, full, empty;
  logic             use_mem, load_out;
  status_e          status_new;
  logic [AW-1:0]    head_prev, head_next, tail_prev, tail_next;
  logic [DATA_WIDTH-1:0] data_ext;
  logic [DATA_WIDTH-1:0] rd_value;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign full     = (count_q == CW'(CAPACITY));
  assign empty    = (count_q == '0);

  assign head_prev = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
  assign head_next = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
  assign tail_prev = (tail_q == '0) ? AW'(CAPACITY - 1) : tail_q - AW'(1);
  assign tail_next = (tail_q == AW'(CAPACITY - 1)) ? '0 : tail_q + AW'(1);

  assign data_ext      = DATA_WIDTH'(req_i.data_in);
  assign mem_wr_data_o = {data_ext, req_i.item_size};
  assign rd_value      = mem_rd_data_i[MW-1:SIZE_W];

  // request decode and pointer update
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    status_new    = ST_OK;
    use_mem       = 1'b0;
    mem_ctl_o     = '0;
    mem_wr_addr_o = tail_q;
    mem_rd_addr_o = head_q;
    if (accept) begin
      case (req_e'(req_i.req_type))
        REQ_PUSH_FRONT: begin
          if (full) begin
            status_new = ST_FULL;
          end else begin
            mem_ctl_o.wr_en = 1'b1;
            mem_wr_addr_o   = head_prev;
            head_d          = head_prev;
            count_d         = count_q + CW'(1);
          end
        end
        REQ_PUSH_BACK: begin
          if (full) begin
            status_new = ST_FULL;
          end else begin
            mem_ctl_o.wr_en = 1'b1;
            mem_wr_addr_o   = tail_q;
            tail_d          = tail_next;
            count_d         = count_q + CW'(1);
          end
        end
        REQ_POP_FRONT, REQ_PEEK_FRONT: begin
          if (empty) begin
            status_new = ST_EMPTY;
          end else begin
            mem_ctl_o.rd_en = 1'b1;
            mem_rd_addr_o   = head_q;
            use_mem         = 1'b1;
            if (req_e'(req_i.req_type) == REQ_POP_FRONT) begin
              head_d  = head_next;
              count_d = count_q - CW'(1);
            end
          end
        end
        REQ_POP_BACK, REQ_PEEK_BACK: begin
          if (empty) begin
            status_new = ST_EMPTY;
          end else begin
            mem_ctl_o.rd_en = 1'b1;
            mem_rd_addr_o   = tail_prev;
            use_mem         = 1'b1;
            if (req_e'(req_i.req_type) == REQ_POP_BACK) begin
              tail_d  = tail_prev;
              count_d = count_q - CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && (use_mem || !out_free)) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_i.ready  = 1'b0;
    load_out     = 1'b0;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_size_d   = out_size_q;
    out_fill_d   = out_fill_q;
    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (accept && !use_mem && out_free) begin
          load_out     = 1'b1;
          out_status_d = status_new;
          out_value_d  = '0;
          out_size_d   = '0;
          out_fill_d   = FILL_W'(count_d);
        end
      end
      S_WAIT: begin
        if (out_free) begin
          load_out     = 1'b1;
          out_status_d = pend_status_q;
          out_value_d  = pend_read_q ? DATA_W'(64'(rd_value)) : '0;
          out_size_d   = pend_read_q ? mem_rd_data_i[SIZE_W-1:0] : '0;
          out_fill_d   = pend_fill_q;
        end
      end
      default: begin
      end
    endcase
    out_valid_d = load_out ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      pend_read_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        pend_read_q <= use_mem;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_status_q <= status_new;
      pend_fill_q   <= FILL_W'(count_d);
    end
    if (load_out) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_size_q   <= out_size_d;
      out_fill_q   <= out_fill_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.out_value  = out_value_q;
  assign rsp_o.out_size   = out_size_q;
  assign rsp_o.fill_count = out_fill_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.wr_en && mem_ctl_o.rd_en))
    else $error("store written and read by the same request");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1))
             || (count_q == $past(count_q) - CW'(1)))
    else $error("entry count moved by more than one");

  a_read_before_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && accept && use_mem |=> (state_q == S_WAIT) && !out_valid_d
                                                 || (state_q == S_WAIT))
    else $error("read transaction did not wait for store data");

  a_refused_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && ((req_i.req_type == REQ_PUSH_FRONT) || (req_i.req_type == REQ_PUSH_BACK))
      |-> !mem_ctl_o.wr_en && (status_new == ST_FULL))
    else $error("push on a full queue reached the store");

endmodule

[rtl/double_ended_queue.sv]
// Fixed-capacity double-ended queue. Each request transaction pushes at the front or back, pops
// from the front or back, or peeks at either end; each returns one response transaction with a
// status (ok, empty, full), the popped or peeked element (zero otherwise) and the element count
// after the request. Elements live in a single-port-read, single-port-write store with a
// registered read; head, tail and count sit in registers. Pushes, refused requests and unused
// codes can be accepted every cycle while the output register is free; a successful pop or
// peek waits for the store read. Results sit in an output register, so a request is taken while
// the previous response waits, and a further request waits while it is occupied or a store read
// is pending. No clearing pass runs after reset: only entries holding live elements are read.
module double_ended_queue #(
  parameter int unsigned CAPACITY   = dq_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_req_if.sink   req_i,
  dq_rsp_if.source rsp_o
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned MW = DATA_WIDTH + SIZE_W;

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [MW-1:0] mem_wr_data, mem_rd_data;

  dq_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .mem_ctl_o     (mem_ctl),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  dq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (MW)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

endmodule
